[hdl/sv39w_pkg.sv]
// shared types and constants of the sv39 translation walker
`timescale 1ns / 1ps
`default_nettype none

package sv39w_pkg;

  localparam int VA_W        = 39;
  localparam int PA_W        = 64;
  localparam int PTE_W       = 64;
  localparam int FRAME_W     = 44;
  localparam int VPN_W       = 9;
  localparam int OFFSET_W    = 12;
  localparam int IDX_W       = 13;
  localparam int CFG_W       = 64;
  localparam int PADDR_W     = 4;
  localparam int ENTRIES_PER_TABLE = 512;
  // entry_index reaches no further than this
  localparam int IDX_DEPTH   = 1 << IDX_W;

  // entry bit positions
  localparam int PTE_V_BIT   = 0;
  localparam int PTE_R_BIT   = 1;
  localparam int PTE_W_BIT   = 2;
  localparam int PTE_X_BIT   = 3;
  localparam int PPN_LSB     = 10;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_UNMAPPED = 2'd1;
  localparam logic [1:0] ST_WINDOW   = 2'd2;

  // which vpn field addresses the table
  localparam logic [1:0] VPN_SEL_0 = 2'd0;
  localparam logic [1:0] VPN_SEL_1 = 2'd1;
  localparam logic [1:0] VPN_SEL_2 = 2'd2;

  // register addresses
  localparam logic [PADDR_W-1:0] ADDR_ROOT = 4'h0;
  localparam logic [PADDR_W-1:0] ADDR_BASE = 4'h8;

  typedef struct packed {
    logic       clr_we;
    logic       accept;
    logic       rd_en;
    logic       from_pte;
    logic [1:0] vpn_sel;
    logic       set_st;
    logic [1:0] st;
    logic       set_pa;
    logic       load_out;
  } walk_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic win_miss;
    logic pte_v;
    logic pte_rwx;
  } walk_sts_t;

endpackage

`default_nettype wire

[hdl/sv39w_channels.sv]
// request and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface sv39w_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [38:0] virtual_address;
  logic [12:0] entry_index;
  logic [63:0] entry_data;

  modport source (output valid, req_type, virtual_address, entry_index, entry_data,
                  input ready);
  modport sink (input valid, req_type, virtual_address, entry_index, entry_data,
                output ready);
endinterface

interface sv39w_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] physical_address;
  logic [1:0]  status;

  modport source (output valid, physical_address, status, input ready);
  modport sink (input valid, physical_address, status, output ready);
endinterface

`default_nettype wire

[hdl/sv39_translation_walker_top.sv]
// top level of the sv39 translation walker: register port and channel wiring
//
//  channel  dir  handshake      payload
//  req      in   valid/ready    req_type, virtual_address, entry_index, entry_data
//  rsp      out  valid/ready    physical_address, status
//  apb      in   psel/penable   paddr 0 root_frame, paddr 8 window_base_frame
//
//  a translate item steps through the issue, eval2, eval1, eval0 and finish
//  states before the next acceptance, going to finish early on a fault; a write
//  item goes straight to finish. the three dependent reads of the table memory,
//  each followed by an entry check, make up the walk. after reset a clearing pass
//  writes zero to every word of the table memory, with no item taken; registers
//  stay writable. the result sits in an output register; a stalled result holds
//  the walker in its final state until it is taken.
`timescale 1ns / 1ps
`default_nettype none

module sv39_translation_walker_top #(
  parameter int TABLE_PAGES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  sv39w_req_if.sink                           req,
  sv39w_rsp_if.source                         rsp,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sv39w_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [sv39w_pkg::CFG_W-1:0]    pwdata,
  output logic      [sv39w_pkg::CFG_W-1:0]    prdata,
  output logic                                pready
);
  import sv39w_pkg::*;

  logic [FRAME_W-1:0] root_frame;
  logic [FRAME_W-1:0] window_base_frame;
  logic               cfg_we;
  walk_cmd_t          cmd;
  walk_sts_t          sts;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  // register select follows the 8-byte slot
  always_ff @(posedge clk) begin
    if (rst) begin
      root_frame        <= '0;
      window_base_frame <= '0;
    end else if (cfg_we) begin
      if (paddr[3] == ADDR_BASE[3]) begin
        window_base_frame <= pwdata[FRAME_W-1:0];
      end else begin
        root_frame <= pwdata[FRAME_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[3] == ADDR_ROOT[3]) begin
      prdata = {{(CFG_W - FRAME_W){1'b0}}, root_frame};
    end else begin
      prdata = {{(CFG_W - FRAME_W){1'b0}}, window_base_frame};
    end
  end

  sv39w_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_type   (req.req_type),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sv39w_path #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_path (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .in_type           (req.req_type),
    .in_va             (req.virtual_address),
    .in_idx            (req.entry_index),
    .in_data           (req.entry_data),
    .root_frame        (root_frame),
    .window_base_frame (window_base_frame),
    .out_pa            (rsp.physical_address),
    .out_st            (rsp.status)
  );

endmodule

`default_nettype wire

[hdl/sv39w_path.sv]
// datapath: table store, window check, entry decode and result registers
`timescale 1ns / 1ps
`default_nettype none

module sv39w_path #(
  parameter int TABLE_PAGES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sv39w_pkg::walk_cmd_t          cmd,
  output sv39w_pkg::walk_sts_t               sts,
  input  wire logic                          in_type,
  input  wire logic [sv39w_pkg::VA_W-1:0]    in_va,
  input  wire logic [sv39w_pkg::IDX_W-1:0]   in_idx,
  input  wire logic [sv39w_pkg::PTE_W-1:0]   in_data,
  input  wire logic [sv39w_pkg::FRAME_W-1:0] root_frame,
  input  wire logic [sv39w_pkg::FRAME_W-1:0] window_base_frame,
  output logic      [sv39w_pkg::PA_W-1:0]    out_pa,
  output logic      [1:0]                    out_st
);
  import sv39w_pkg::*;

  localparam int FULL_DEPTH = TABLE_PAGES * ENTRIES_PER_TABLE;
  // entries past the reach of entry_index are never written and read as zero
  localparam int MEM_DEPTH  = (FULL_DEPTH < IDX_DEPTH) ? FULL_DEPTH : IDX_DEPTH;
  localparam int MEM_AW     = $clog2(MEM_DEPTH);
  localparam int PAGE_W     = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
  localparam int RA_W       = PAGE_W + VPN_W;

  localparam logic [FRAME_W-1:0] PAGES_F  = FRAME_W'(TABLE_PAGES);
  localparam logic [RA_W:0]      DEPTH_RA = (RA_W + 1)'(MEM_DEPTH);
  localparam logic [IDX_W:0]     DEPTH_IX = (IDX_W + 1)'(MEM_DEPTH);
  localparam logic [MEM_AW-1:0]  LAST_CLR = MEM_AW'(MEM_DEPTH - 1);

  logic [PTE_W-1:0]   store [MEM_DEPTH];
  logic [PTE_W-1:0]   mem_q;
  logic               beyond_q;
  logic [MEM_AW-1:0]  clr_cnt;
  logic [VA_W-1:0]    va_q;
  logic [PA_W-1:0]    res_pa;
  logic [1:0]         res_st;

  logic [PTE_W-1:0]   pte;
  logic [FRAME_W-1:0] pte_ppn;
  logic [FRAME_W-1:0] chk_frame;
  logic [FRAME_W-1:0] page_diff;
  logic [VPN_W-1:0]   slot;
  logic [RA_W-1:0]    rd_addr;
  logic               wr_en;
  logic [MEM_AW-1:0]  wr_addr;
  logic [PTE_W-1:0]   wr_data;

  assign pte     = beyond_q ? '0 : mem_q;
  assign pte_ppn = pte[PPN_LSB +: FRAME_W];

  // window check on the frame of the table about to be read
  assign chk_frame = cmd.from_pte ? pte_ppn : root_frame;
  assign page_diff = chk_frame - window_base_frame;

  always_comb begin
    unique case (cmd.vpn_sel)
      VPN_SEL_2: slot = va_q[OFFSET_W + 2*VPN_W +: VPN_W];
      VPN_SEL_1: slot = va_q[OFFSET_W + VPN_W +: VPN_W];
      VPN_SEL_0: slot = va_q[OFFSET_W +: VPN_W];
      default:   slot = va_q[OFFSET_W +: VPN_W];
    endcase
  end

  assign rd_addr = {page_diff[PAGE_W-1:0], slot};

  assign sts.win_miss = (chk_frame < window_base_frame) || (page_diff >= PAGES_F);
  assign sts.pte_v    = pte[PTE_V_BIT];
  assign sts.pte_rwx  = pte[PTE_R_BIT] | pte[PTE_W_BIT] | pte[PTE_X_BIT];
  assign sts.clr_last = (clr_cnt == LAST_CLR);

  // one write port shared by the clearing pass and write items
  assign wr_en   = cmd.clr_we | (cmd.accept & in_type & ({1'b0, in_idx} < DEPTH_IX));
  assign wr_addr = cmd.clr_we ? clr_cnt : in_idx[MEM_AW-1:0];
  assign wr_data = cmd.clr_we ? '0 : in_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      mem_q    <= store[rd_addr[MEM_AW-1:0]];
      beyond_q <= ({1'b0, rd_addr} >= DEPTH_RA);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_we && !sts.clr_last) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      va_q   <= in_va;
      res_pa <= '0;
      res_st <= ST_OK;
    end else begin
      if (cmd.set_st) begin
        res_st <= cmd.st;
      end
      if (cmd.set_pa) begin
        res_pa <= {{(PA_W - FRAME_W - OFFSET_W){1'b0}}, pte_ppn, va_q[OFFSET_W-1:0]};
      end
    end
    if (cmd.load_out) begin
      out_pa <= res_pa;
      out_st <= res_st;
    end
  end

endmodule

`default_nettype wire

[hdl/sv39w_ctrl.sv]
// walk controller: clearing pass, level sequencing and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module sv39w_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  input  wire logic                 in_type,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire sv39w_pkg::walk_sts_t sts,
  output sv39w_pkg::walk_cmd_t      cmd
);
  import sv39w_pkg::*;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ISSUE  = 3'd2;
  localparam logic [2:0] S_EVAL2  = 3'd3;
  localparam logic [2:0] S_EVAL1  = 3'd4;
  localparam logic [2:0] S_EVAL0  = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_we = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = in_type ? S_FINISH : S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd.vpn_sel = VPN_SEL_2;
        if (sts.win_miss) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_WINDOW;
          state_next = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_EVAL2;
        end
      end
      S_EVAL2, S_EVAL1: begin
        cmd.from_pte = 1'b1;
        cmd.vpn_sel  = (state == S_EVAL2) ? VPN_SEL_1 : VPN_SEL_0;
        // directory levels need a valid pointer, superpages count as unmapped
        if (!sts.pte_v || sts.pte_rwx) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_UNMAPPED;
          state_next = S_FINISH;
        end else if (sts.win_miss) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_WINDOW;
          state_next = S_FINISH;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = (state == S_EVAL2) ? S_EVAL1 : S_EVAL0;
        end
      end
      S_EVAL0: begin
        if (!sts.pte_v) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_UNMAPPED;
        end else begin
          cmd.set_pa = 1'b1;
        end
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) $fell(rst) |-> (state == S_CLEAR))
    else $error("clearing pass did not start after reset");

  a_read_then_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |=> (state == S_EVAL2 || state == S_EVAL1 || state == S_EVAL0))
    else $error("table read not followed by entry evaluation");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("pending result overwritten");

  a_one_item_at_once: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item accepted while another is in flight");

endmodule

`default_nettype wire

[test/tb_sv39_translation_walker_top.sv]
// testbench of the sv39 translation walker: directed walks and faults, then random table traffic
`timescale 1ns / 1ps

module tb_sv39_translation_walker_top;
  import sv39w_pkg::*;

  localparam int TABLE_PAGES   = 16;
  localparam int STORE_DEPTH   = (TABLE_PAGES * ENTRIES_PER_TABLE < IDX_DEPTH) ?
                                 TABLE_PAGES * ENTRIES_PER_TABLE : IDX_DEPTH;
  localparam logic REQ_TRANSLATE = 1'b0;
  localparam logic REQ_WRITE     = 1'b1;
  localparam logic [FRAME_W-1:0] FRAME_MAX = '1;
  localparam logic [FRAME_W-1:0] W_BASE    = 44'h10;
  localparam logic [9:0] F_V = 10'd1 << PTE_V_BIT;
  localparam logic [9:0] F_R = 10'd1 << PTE_R_BIT;
  localparam logic [9:0] F_W = 10'd1 << PTE_W_BIT;
  localparam logic [9:0] F_X = 10'd1 << PTE_X_BIT;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 50000;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 210;

  typedef struct packed {
    logic [PA_W-1:0] pa;
    logic [1:0]      st;
  } walk_result_t;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [CFG_W-1:0]   pwdata;
  logic [CFG_W-1:0]   prdata;
  logic               pready;

  sv39w_req_if req_ch();
  sv39w_rsp_if rsp_ch();

  sv39_translation_walker_top #(.TABLE_PAGES(TABLE_PAGES)) DUT (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // mirror of the walker state
  logic [PTE_W-1:0]   table_mirror [STORE_DEPTH];
  logic [FRAME_W-1:0] root_frame_cfg;
  logic [FRAME_W-1:0] window_base_cfg;
  logic [VPN_W-1:0]   slot_pool [4];

  walk_result_t expected_walks [$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  bit quiet_phase = 1'b0;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < 100) $display("mismatch at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [FRAME_W-1:0] rand44();
    return {12'($urandom_range(0, 4095)), 32'($urandom())};
  endfunction

  function automatic logic [63:0] rand64();
    return {32'($urandom()), 32'($urandom())};
  endfunction

  // bits 54..63 are random: the walker must ignore them
  function automatic logic [PTE_W-1:0] make_entry(input logic [FRAME_W-1:0] frame,
                                                  input logic [9:0] flags);
    return {10'($urandom_range(0, 1023)), frame, flags};
  endfunction

  function automatic logic [VA_W-1:0] make_va(input logic [VPN_W-1:0] v2,
                                              input logic [VPN_W-1:0] v1,
                                              input logic [VPN_W-1:0] v0,
                                              input logic [OFFSET_W-1:0] off);
    return {v2, v1, v0, off};
  endfunction

  function automatic logic [IDX_W-1:0] slot_index(input int page, input logic [VPN_W-1:0] slot);
    return IDX_W'(page * ENTRIES_PER_TABLE) + IDX_W'(slot);
  endfunction

  // false when the table frame lies outside the window
  function automatic bit fetch_entry(input logic [FRAME_W-1:0] frame,
                                     input logic [VPN_W-1:0] slot,
                                     output logic [PTE_W-1:0] pte);
    logic [FRAME_W-1:0] page;
    pte = '0;
    if (frame < window_base_cfg) return 1'b0;
    page = frame - window_base_cfg;
    if (page >= FRAME_W'(TABLE_PAGES)) return 1'b0;
    pte = table_mirror[int'(page) * ENTRIES_PER_TABLE + int'(slot)];
    return 1'b1;
  endfunction

  function automatic walk_result_t predict_walk(input logic [VA_W-1:0] va);
    walk_result_t r;
    logic [FRAME_W-1:0] frame;
    logic [PTE_W-1:0]   pte;
    r.pa = '0;
    r.st = ST_OK;
    frame = root_frame_cfg;
    for (int level = 2; level > 0; level--) begin
      if (!fetch_entry(frame, va[OFFSET_W + VPN_W * level +: VPN_W], pte)) begin
        r.st = ST_WINDOW;
        return r;
      end
      // upper levels need a pointer: valid with r, w and x clear
      if (!pte[PTE_V_BIT] || pte[PTE_X_BIT:PTE_R_BIT] != 3'b000) begin
        r.st = ST_UNMAPPED;
        return r;
      end
      frame = pte[PPN_LSB +: FRAME_W];
    end
    if (!fetch_entry(frame, va[OFFSET_W +: VPN_W], pte)) begin
      r.st = ST_WINDOW;
      return r;
    end
    if (!pte[PTE_V_BIT]) begin
      r.st = ST_UNMAPPED;
      return r;
    end
    r.pa = {8'h00, pte[PPN_LSB +: FRAME_W], va[OFFSET_W-1:0]};
    return r;
  endfunction

  task automatic send_req(input logic kind, input logic [VA_W-1:0] va,
                          input logic [IDX_W-1:0] idx, input logic [PTE_W-1:0] data);
    int gap;
    walk_result_t outcome;
    req_ch.valid           <= 1'b1;
    req_ch.req_type        <= kind;
    req_ch.virtual_address <= va;
    req_ch.entry_index     <= idx;
    req_ch.entry_data      <= data;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    if (kind == REQ_WRITE) begin
      if (idx < STORE_DEPTH) table_mirror[idx] = data;
      outcome.pa = '0;
      outcome.st = ST_OK;
    end else begin
      outcome = predict_walk(va);
    end
    expected_walks.push_back(outcome);
    gap = quiet_phase ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_translate(input logic [VA_W-1:0] va);
    send_req(REQ_TRANSLATE, va, IDX_W'($urandom_range(0, IDX_DEPTH - 1)), rand64());
  endtask

  task automatic send_write(input logic [IDX_W-1:0] idx, input logic [PTE_W-1:0] data);
    send_req(REQ_WRITE, {7'($urandom_range(0, 127)), 32'($urandom())}, idx, data);
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (expected_walks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write then read back over the register port
  task automatic program_register(input logic [PADDR_W-1:0] addr,
                                  input logic [FRAME_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= CFG_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (addr == ADDR_ROOT) begin
      root_frame_cfg = value;
    end else if (addr == ADDR_BASE) begin
      window_base_cfg = value;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== CFG_W'(value))
      report_mismatch($sformatf("register %h reads %h, expected %h", addr, prdata, value));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // root at page 0, level-1 table at page 1, level-0 table at page 2
  task automatic test_full_walks();
    program_register(ADDR_BASE, W_BASE);
    program_register(ADDR_ROOT, W_BASE);
    send_write(slot_index(0, 511), make_entry(W_BASE + 44'd1, F_V));
    send_write(slot_index(1, 0), make_entry(W_BASE + 44'd2, F_V));
    send_write(slot_index(2, 511), 64'hFFFF_FFFF_FFFF_FC01);
    send_translate(make_va(511, 0, 511, 12'hfff));
    send_translate(make_va(511, 0, 511, 12'h000));
    // level-0 leaf with r, w and x set still maps
    send_write(slot_index(2, 0), {54'h0, F_X | F_W | F_R | F_V});
    send_translate(make_va(511, 0, 0, 12'h5a5));
  endtask

  task automatic test_unmapped_entries();
    send_translate('0);
    send_translate('1);
    send_write(slot_index(0, 1), make_entry(W_BASE + 44'd3, F_V | F_R));
    send_translate(make_va(1, 0, 0, 12'h000));
    send_write(slot_index(1, 1), make_entry(W_BASE + 44'd3, F_V | F_X | F_W));
    send_translate(make_va(511, 1, 0, 12'h000));
    send_translate(make_va(511, 0, 5, 12'h010));
  endtask

  task automatic test_window_faults();
    send_write(slot_index(0, 2), make_entry(W_BASE - 44'd1, F_V));
    send_translate(make_va(2, 0, 0, 12'h000));
    send_write(slot_index(1, 3), make_entry(W_BASE + 44'd16, F_V));
    send_translate(make_va(511, 3, 0, 12'h000));
    send_write('1, '1);
    send_write('0, '0);
  endtask

  task automatic test_root_settings();
    wait_idle();
    program_register(ADDR_ROOT, W_BASE + 44'd16);
    send_translate(make_va(511, 0, 511, 12'h000));
    wait_idle();
    program_register(ADDR_ROOT, W_BASE - 44'd1);
    send_translate(make_va(511, 0, 511, 12'h000));
    wait_idle();
    program_register(ADDR_BASE, '0);
    program_register(ADDR_ROOT, 44'd15);
    send_translate(make_va(511, 0, 0, 12'h000));
    wait_idle();
    program_register(ADDR_BASE, FRAME_MAX);
    program_register(ADDR_ROOT, FRAME_MAX);
    send_translate('0);
  endtask

  // tables are built on a few shared slots so that most walks go deep
  task automatic test_random_traffic();
    logic [FRAME_W-1:0] base;
    logic [FRAME_W-1:0] root;
    logic [FRAME_W-1:0] frame;
    logic [PTE_W-1:0]   entry;
    logic [IDX_W-1:0]   idx;
    logic [VA_W-1:0]    va;
    int reach;
    int pick;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_idle();
      case (phase)
        0: base = '0;
        1: base = FRAME_MAX - 44'd15;
        2: base = FRAME_MAX;
        default: base = rand44();
      endcase
      // pages above the base, at most 15, that do not pass the top frame
      reach = (FRAME_MAX - base < 44'd15) ? int'(FRAME_MAX - base) : 15;
      case (phase)
        0: root = base;
        1: root = base + 44'(reach);
        default: begin
          root = ($urandom_range(0, 5) == 0) ? rand44() : base + 44'($urandom_range(0, reach));
        end
      endcase
      program_register(ADDR_BASE, base);
      program_register(ADDR_ROOT, root);
      foreach (slot_pool[k]) slot_pool[k] = VPN_W'($urandom_range(0, 511));
      slot_pool[0] = phase[0] ? '0 : '1;
      quiet_phase = phase[0];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < (n < 40 ? 70 : 35)) begin
          pick = $urandom_range(0, 99);
          frame = base + 44'($urandom_range(0, reach));
          if (pick < 45) begin
            entry = make_entry(frame, {6'($urandom_range(0, 63)), 3'b000, 1'b1});
          end else if (pick < 65) begin
            entry = make_entry(rand44(), {6'($urandom_range(0, 63)),
                                          3'($urandom_range(1, 7)), 1'b1});
          end else if (pick < 75) begin
            entry = make_entry(frame, {9'($urandom_range(0, 511)), 1'b0});
          end else if (pick < 85) begin
            frame = $urandom_range(0, 1) ? base + 44'(16 + $urandom_range(0, 99)) :
                                           base - 44'(1 + $urandom_range(0, 99));
            entry = make_entry(frame, F_V);
          end else begin
            entry = rand64();
          end
          if ($urandom_range(0, 99) < 85)
            idx = slot_index($urandom_range(0, TABLE_PAGES - 1), slot_pool[$urandom_range(0, 3)]);
          else
            idx = IDX_W'($urandom_range(0, IDX_DEPTH - 1));
          send_write(idx, entry);
        end else begin
          if ($urandom_range(0, 99) < 85)
            va = make_va(slot_pool[$urandom_range(0, 3)], slot_pool[$urandom_range(0, 3)],
                         slot_pool[$urandom_range(0, 3)], 12'($urandom_range(0, 4095)));
          else
            va = {7'($urandom_range(0, 127)), 32'($urandom())};
          send_translate(va);
        end
      end
    end
    wait_idle();
    quiet_phase = 1'b0;
  endtask

  initial begin : result_stall
    int hold;
    hold = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        rsp_ch.ready <= 1'b0;
        hold--;
      end else begin
        rsp_ch.ready <= 1'b1;
        if (!quiet_phase && $urandom_range(0, 3) == 0) hold = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : check_results
    walk_result_t oldest;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      if (expected_walks.size() == 0) begin
        report_mismatch($sformatf("result %h/%0d with no item waiting",
                                  rsp_ch.physical_address, rsp_ch.status));
      end else begin
        oldest = expected_walks.pop_front();
        if (rsp_ch.physical_address !== oldest.pa)
          report_mismatch($sformatf("physical_address %h, expected %h",
                                    rsp_ch.physical_address, oldest.pa));
        if (rsp_ch.status !== oldest.st)
          report_mismatch($sformatf("status %0d, expected %0d", rsp_ch.status, oldest.st));
      end
    end
  end

  // covers the clearing pass after reset as well
  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    req_ch.valid           <= 1'b0;
    req_ch.req_type        <= REQ_TRANSLATE;
    req_ch.virtual_address <= '0;
    req_ch.entry_index     <= '0;
    req_ch.entry_data      <= '0;
    foreach (table_mirror[i]) table_mirror[i] = '0;
    root_frame_cfg  = '0;
    window_base_cfg = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_full_walks();
    test_unmapped_entries();
    test_window_faults();
    test_root_settings();
    test_random_traffic();
    wait_idle();
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
